FILE: design/dds_tuning_word_sequencer_assert.svh
// Assertion macros used by the back end of the tuning word sequencer RTL.
`ifndef DDS_TUNING_WORD_SEQUENCER_ASSERT_SVH
`define DDS_TUNING_WORD_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define DTWS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("dtws assertion failed");
`define DTWS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("dtws assertion failed");
`else
`define DTWS_ASSERT_IMP(lbl, a, b)
`define DTWS_ASSERT_NXT(lbl, a, b)
`endif

`endif

FILE: design/dtws_pkg.sv
// Shared constants and types of the tuning word sequencer.
`default_nettype none

package dtws_pkg;

  localparam int TUNING_BITS_DEF = 28;
  localparam int FREQ_W          = 32;
  localparam int CLK_W           = 28;
  localparam int WORD_W          = 16;
  localparam int HALF_W          = 14;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CLK_W-1:0]  CLK_RESET_HZ    = 28'd25000000;
  localparam logic [WORD_W-1:0] CTRL_RESET_WORD = 16'h2100;
  localparam logic [WORD_W-1:0] CTRL_RUN_WORD   = 16'h2000;
  localparam logic [WORD_W-1:0] FREQ0_LOAD      = 16'h4000;

  // One queued request.
  typedef struct packed {
    logic              enable;
    logic [FREQ_W-1:0] freq;
  } req_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: design/dtws_front.sv
// Input side: accepts requests and holds them in a short queue for the back end.
`default_nettype none

module dtws_front
  import dtws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [FREQ_W-1:0] in_tdata,
  input  wire logic              in_tuser,
  output logic                   q_valid,
  output req_t                   q_data,
  input  wire logic              q_pop
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t           mem_r [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;
  logic           pop;
  req_t           req;

  assign in_tready = (count_r != CW'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_data    = mem_r[rd_ptr_r];

  always_comb begin
    req.enable = in_tuser;
    req.freq   = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= req;
    end
  end

endmodule

`default_nettype wire

FILE: design/dtws_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded tuning word.
`default_nettype none

module dtws_div
  import dtws_pkg::*;
#(
  parameter int TUNING_BITS = TUNING_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [FREQ_W-1:0]      freq,
  input  wire logic [CLK_W-1:0]       clk_hz,
  output div_status_t                 status,
  output logic [TUNING_BITS-1:0]      quot
);

  localparam int NW = FREQ_W + TUNING_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]          num_r;
  logic [CLK_W-1:0]       rem_r;
  logic [TUNING_BITS-1:0] quot_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [NW-1:0]          num_init;
  logic [CLK_W:0]         rem2;
  logic [CLK_W:0]         diff;
  logic                   ge;

  // Rounding adds half the divisor before the divide.
  assign num_init = {1'b0, freq, {TUNING_BITS{1'b0}}} + NW'(clk_hz >> 1);
  assign rem2     = {rem_r, num_r[NW-1]};
  assign ge       = (rem2 >= {1'b0, clk_hz});
  assign diff     = rem2 - {1'b0, clk_hz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // A zero divisor makes every step subtract, so the quotient comes out all ones.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num_init;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[NW-2:0], 1'b0};
      rem_r  <= ge ? diff[CLK_W-1:0] : rem2[CLK_W-1:0];
      quot_r <= {quot_r[TUNING_BITS-2:0], ge};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quot        = quot_r;

endmodule

`default_nettype wire

FILE: design/dtws_back.sv
// Back end: runs the divide for each queued request and emits its four command words.
`default_nettype none

module dtws_back
  import dtws_pkg::*;
#(
  parameter int TUNING_BITS = TUNING_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CLK_W-1:0]  clk_hz,
  input  wire logic              q_valid,
  input  req_t                   q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WORD_W-1:0]      out_tdata,
  output logic                   out_tlast
);

`include "dds_tuning_word_sequencer_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   en_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      out_word_r;
  logic                   out_last_r;
  logic                   out_free;
  logic                   load;
  logic [WORD_W-1:0]      word;
  logic [31:0]            tw32;
  logic [TUNING_BITS-1:0] quot;
  div_status_t            div_st;

  dtws_div #(.TUNING_BITS(TUNING_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (q_pop),
    .freq   (q_data.freq),
    .clk_hz (clk_hz),
    .status (div_st),
    .quot   (quot)
  );

  assign tw32     = 32'(quot);
  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign load     = (state_r == ST_EMIT) && out_free;

  always_comb begin
    case (idx_r)
      2'd0:    word = CTRL_RESET_WORD;
      2'd1:    word = FREQ0_LOAD | {2'b00, tw32[HALF_W-1:0]};
      2'd2:    word = FREQ0_LOAD | {2'b00, tw32[2*HALF_W-1:HALF_W]};
      default: word = en_r ? CTRL_RUN_WORD : CTRL_RESET_WORD;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_nxt = ST_EMIT;
          idx_nxt   = 2'd0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      en_r <= q_data.enable;
    end
    if (load) begin
      out_word_r <= word;
      out_last_r <= (idx_r == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

  `DTWS_ASSERT_IMP(a_done_in_div, div_st.done, state_r == ST_DIV)
  `DTWS_ASSERT_NXT(a_done_to_emit, (state_r == ST_DIV) && div_st.done,
                   (state_r == ST_EMIT) && (idx_r == 2'd0))
  `DTWS_ASSERT_IMP(a_emit_div_idle, state_r == ST_EMIT, !div_st.busy)
  `DTWS_ASSERT_IMP(a_last_is_ctrl, out_valid_r && out_last_r,
                   (out_word_r == CTRL_RUN_WORD) || (out_word_r == CTRL_RESET_WORD))

endmodule

`default_nettype wire

FILE: design/dds_tuning_word_sequencer.sv
// Top level of the DDS tuning word sequencer: config register, request queue, back end.
//
// Usage:
// Each input item on in_* carries a frequency in hertz (in_tdata) and an enable
// flag (in_tuser). For every item the block sends four 16-bit command words on
// out_*: a reset control word, two frequency register loads with the low and
// high 14-bit halves of the rounded tuning word, and a run or reset control word
// chosen by the enable flag; out_tlast marks the fourth word.
// The master clock in hertz is written through the cfg_ APB port at address 0
// and should only be changed while no item is in flight.
// The tuning word comes from a restoring divider that produces one quotient
// bit per cycle over TUNING_BITS+33 steps; the four words follow once the
// divide is done. A two-entry queue takes new items while an earlier one is
// being worked on.
// Reset sets the master clock to 25 MHz and empties the queue and output stage;
// there is no clearing pass. When the receiver stalls, the held word stays on
// out_tdata and the sequencer waits; the queue then fills and in_tready drops.
`default_nettype none

module dds_tuning_word_sequencer
  import dtws_pkg::*;
#(
  parameter int TUNING_BITS = TUNING_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,    // [31:0] freq_hz
  input  wire logic              in_tuser,    // [0] enable
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,   // [15:0] command_word
  output logic                   out_tlast,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [CLK_W-1:0] clk_hz_r;
  logic             cfg_wr;
  logic             q_valid;
  logic             q_pop;
  req_t             q_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(clk_hz_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET_HZ;
    end else if (cfg_wr) begin
      clk_hz_r <= cfg_pwdata[CLK_W-1:0];
    end
  end

  dtws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  dtws_back #(.TUNING_BITS(TUNING_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clk_hz     (clk_hz_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: dv/dds_tuning_word_sequencer_test.sv
// Testbench for the DDS tuning word sequencer: predicts the four command words of each item.
`timescale 1ns / 1ps

module dds_tuning_word_sequencer_test;
  import dtws_pkg::*;

  localparam int TW_BITS = TUNING_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [2:0] MASTER_CLOCK_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_REG_ADDR = 3'd4;
  localparam logic [CLK_W-1:0] CLK_MAX_HZ = 28'd200000000;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } command_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  command_word_t    expected_words[$];
  command_word_t    oldest_word;
  logic [CLK_W-1:0] master_clock_model = CLK_RESET_HZ;
  int               error_count = 0;
  int               item_count = 0;
  int               word_count = 0;
  int               clock_settings = 1;
  int               cycle_count = 0;
  int               stall_request = 0;
  bit               sender_no_gap = 1'b0;
  bit               receiver_no_stall = 1'b0;

  dds_tuning_word_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] freq_hz
    .in_tuser   (in_tuser),     // [0] enable
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [15:0] command_word
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // Rounded tuning word; the whole multiples of the clock vanish modulo 2^TW_BITS.
  function automatic logic [TW_BITS-1:0] tuning_word_for(logic [31:0] freq,
                                                         logic [CLK_W-1:0] clk_hz);
    logic [63:0] rem;
    logic [63:0] num;
    if (clk_hz == '0) return '1;
    rem = 64'(freq % 32'(clk_hz));
    num = (rem << TW_BITS) + 64'(clk_hz >> 1);
    return TW_BITS'(num / 64'(clk_hz));
  endfunction

  task automatic queue_command_words(logic [31:0] freq, logic enable);
    logic [TW_BITS-1:0] tw;
    tw = tuning_word_for(freq, master_clock_model);
    expected_words.push_back('{CTRL_RESET_WORD, 1'b0});
    expected_words.push_back('{FREQ0_LOAD | {2'b00, tw[HALF_W-1:0]}, 1'b0});
    expected_words.push_back('{FREQ0_LOAD | {2'b00, tw[2*HALF_W-1:HALF_W]}, 1'b0});
    expected_words.push_back('{enable ? CTRL_RUN_WORD : CTRL_RESET_WORD, 1'b1});
  endtask

  // Returns at the edge where the item is taken, with in_tvalid still high.
  task automatic send_item(logic [31:0] freq, logic enable);
    int gap;
    gap = sender_no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= freq;
    in_tuser  <= enable;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queue_command_words(freq, enable);
    item_count++;
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (addr == MASTER_CLOCK_ADDR) begin
      master_clock_model = data[CLK_W-1:0];
      clock_settings++;
    end
  endtask

  task automatic check_clock_register();
    logic [31:0] value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= MASTER_CLOCK_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (value != 32'(master_clock_model)) begin
      $display("%0t: master clock readback expected %h actual %h",
               $realtime, 32'(master_clock_model), value);
      error_count++;
    end
  endtask

  function automatic logic [31:0] random_frequency();
    logic [31:0] k;
    if (master_clock_model == '0) return $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 32'(master_clock_model) - 1);
      7, 8: begin
        // Halfway between two whole multiples of the clock, or one hertz below that.
        k = $urandom_range(0, 32'hFFFF_FFFF / 32'(master_clock_model));
        return k * 32'(master_clock_model) + 32'(master_clock_model >> 1)
               - $urandom_range(0, 1);
      end
      default: return 32'(master_clock_model) - 1;
    endcase
  endfunction

  function automatic logic [CLK_W-1:0] random_clock();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 32'(CLK_MAX_HZ));
      1:       return $urandom_range(1, 1000);
      2:       return $urandom_range(1, 32'h0FFF_FFFF);
      3:       return CLK_RESET_HZ;
      4:       return CLK_MAX_HZ;
      default: return '0;
    endcase
  endfunction

  task automatic test_reset_clock();
    check_clock_register();
    send_item(32'd0, 1'b1);
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'd1, 1'b0);
    send_item(32'd12500000, 1'b1);
    send_item(32'd24999999, 1'b1);
    send_item(32'd25000000, 1'b0);
    wait_until_idle();
  endtask

  task automatic test_clock_extremes();
    logic [CLK_W-1:0] settings[4];
    settings = '{28'd1, CLK_MAX_HZ, 28'd0, 28'hFFF_FFFF};
    foreach (settings[i]) begin
      write_register(MASTER_CLOCK_ADDR, 32'(settings[i]));
      check_clock_register();
      send_item(32'hFFFF_FFFF, 1'b1);
      send_item(32'(settings[i]) - 1, 1'b0);
      send_item(32'(settings[i] >> 1), 1'b1);
      wait_until_idle();
    end
    // Bits above the register width are dropped.
    write_register(MASTER_CLOCK_ADDR, 32'hF000_0003);
    check_clock_register();
    send_item(32'd2, 1'b1);
    wait_until_idle();
    // A write beyond the register list leaves the clock as it was.
    write_register(UNUSED_REG_ADDR, 32'h0000_1234);
    check_clock_register();
    send_item(32'h8000_0001, 1'b0);
    wait_until_idle();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      write_register(MASTER_CLOCK_ADDR, {4'($urandom_range(0, 15)), random_clock()});
      for (int n = 0; n < 45; n++) begin
        if (n % 10 == 0) begin
          sender_no_gap     = ($urandom_range(0, 3) == 0);
          receiver_no_stall = ($urandom_range(0, 3) == 0);
        end
        if (n == 25) wait_until_idle();
        send_item(random_frequency(), 1'($urandom));
      end
      wait_until_idle();
    end
    sender_no_gap     = 1'b0;
    receiver_no_stall = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_register(MASTER_CLOCK_ADDR, 32'(CLK_RESET_HZ));
    sender_no_gap = 1'b1;
    stall_request = 300;
    repeat (10) send_item($urandom, 1'($urandom));
    sender_no_gap = 1'b0;
    wait_until_idle();
  endtask

  // Receiver: a random stall before each word, or a long one when a test asks.
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        stall = stall_request;
        stall_request = 0;
      end else begin
        stall = receiver_no_stall ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      word_count++;
      if (expected_words.size() == 0) begin
        $display("%0t: command word expected none actual %h last %b",
                 $realtime, out_tdata, out_tlast);
        error_count++;
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_tdata !== oldest_word.word) begin
          $display("%0t: command word expected %h actual %h",
                   $realtime, oldest_word.word, out_tdata);
          error_count++;
        end
        if (out_tlast !== oldest_word.last) begin
          $display("%0t: last flag expected %b actual %b",
                   $realtime, oldest_word.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_clock();
    test_clock_extremes();
    test_random_phases();
    test_output_backpressure();
    $display("Sent %0d frequency items under %0d clock settings, checked %0d command words.",
             item_count, clock_settings, word_count);
    $display("Covered zero, maximum and masked clocks, long output stalls and full bursts.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
